// File: sv/skh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the solenoid kick/hold sequencer.
package skh_pkg;

    localparam int NUM_CHANNELS  = 8;
    localparam int QUALIFY_US    = 50;
    localparam int PWM_PERIOD_MS = 16;
    localparam int US_PER_MS     = 1000;

    localparam int CH_SLOTS = 8;
    localparam int CH_W     = 3;

    localparam logic [CH_SLOTS-1:0] CHAN_MASK = CH_SLOTS'((1 << NUM_CHANNELS) - 1);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_QUAL = 3'd1,
        PH_KICK = 3'd2,
        PH_SUST = 3'd3,
        PH_WAIT = 3'd4,
        PH_OFF  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        REG_ENABLE_MASK     = 3'd0,
        REG_USE_SWITCH_MASK = 3'd1,
        REG_AUTO_CLEAR_MASK = 3'd2,
        REG_KICK_TIME_TABLE = 3'd3,
        REG_MIN_OFF_TABLE   = 3'd4,
        REG_DUTY_TABLE      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]  switch_levels;
        logic [7:0]  proc_requests;
        logic [31:0] now_us;
        logic [7:0]  valid_ack;
    } in_item_t;

    typedef struct packed {
        logic [7:0] drive;
        logic [7:0] valid_switch;
        logic [7:0] request_clear;
        logic [2:0] served_channel;
        logic [2:0] served_phase;
    } out_item_t;

endpackage

// File: sv/solenoid_kick_hold_sequencer.sv
`timescale 1ns / 1ps
// Solenoid kick/hold sequencer: one channel served per poll request, round-robin.
//
// Each poll request yields exactly one result. A request is registered on
// acceptance; once the output register is free or being emptied, the served
// channel's phase machine is updated from the input register while the result
// is loaded into the output register. A new request is taken every cycle (one
// request per cycle sustained) while the output is not stalled; a stalled
// output backs up into the input register and then into in_ready. The
// per-channel read-modify-write lies between the input and output registers.
// Millisecond timeouts are compared against the elapsed microsecond
// count scaled by 1000, so no divider is present. Configuration writes are
// always accepted and are meant to be issued only while no poll is in flight.
module solenoid_kick_hold_sequencer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  skh_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output skh_pkg::out_item_t  out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import skh_pkg::*;

    // configuration
    logic [7:0]  enable_mask_reg;
    logic [7:0]  use_switch_mask_reg;
    logic [7:0]  auto_clear_mask_reg;
    logic [63:0] kick_time_table_reg;
    logic [31:0] min_off_table_reg;
    logic [31:0] duty_table_reg;

    // channel state
    phase_t      phase_reg      [CH_SLOTS];
    logic [4:0]  off_count_reg  [CH_SLOTS];
    logic        saw_release_reg[CH_SLOTS];
    logic [31:0] start_us_reg   [CH_SLOTS];
    logic [7:0]  drive_bits_reg;
    logic [7:0]  valid_bits_reg;
    logic [CH_W-1:0] cur_chan_reg;

    // pipeline
    logic        in_vld_reg;
    in_item_t    in_reg;
    logic        out_vld_reg;
    out_item_t   out_reg;
    logic        process;

    // update logic
    logic [7:0]      en;
    logic            any_en;
    logic [CH_W-1:0] ch;
    logic [CH_W-1:0] idx;
    logic            found;
    logic [CH_W-1:0] next_ch;
    logic [CH_W-1:0] idx2;
    logic            found2;
    logic [7:0]      bit_sel;
    logic [7:0]      kick_ms;
    logic [3:0]      minoff;
    logic [3:0]      dur;
    logic            act;
    logic [31:0]     el_us;
    logic [31:0]     kick_thr_us;
    logic            kick_done;
    logic            sust_over;
    logic            sust_on;
    logic [7:0]      mirror;
    logic [7:0]      ack_valid;
    phase_t          ph_next;
    logic [4:0]      off_next;
    logic            saw_next;
    logic            start_wr;
    logic [7:0]      drive_next;
    logic [7:0]      valid_next;
    logic [7:0]      clr;

    assign process   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || process;
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        en        = enable_mask_reg & CHAN_MASK;
        any_en    = |en;
        ack_valid = valid_bits_reg & ~in_reg.valid_ack;

        // first enabled channel at or after the round-robin pointer
        ch    = cur_chan_reg;
        idx   = cur_chan_reg;
        found = 1'b0;
        for (int k = 0; k < CH_SLOTS; k++)
        begin
            idx = cur_chan_reg + CH_W'(k);
            if (!found && en[idx])
            begin
                ch    = idx;
                found = 1'b1;
            end
        end

        // next enabled channel after the served one
        next_ch = ch;
        idx2    = ch;
        found2  = 1'b0;
        for (int k = 1; k <= CH_SLOTS; k++)
        begin
            idx2 = ch + CH_W'(k);
            if (!found2 && en[idx2])
            begin
                next_ch = idx2;
                found2  = 1'b1;
            end
        end

        bit_sel = 8'(1) << ch;
        kick_ms = kick_time_table_reg[8*ch +: 8];
        minoff  = min_off_table_reg[4*ch +: 4];
        dur     = duty_table_reg[4*ch +: 4];
        act     = ((use_switch_mask_reg & bit_sel) != 8'd0
                   && (in_reg.switch_levels & bit_sel) == 8'd0)
                  || (in_reg.proc_requests & bit_sel) != 8'd0;
        el_us   = in_reg.now_us - start_us_reg[ch];

        // elapsed ms >= kick  <=>  elapsed us >= kick * 1000
        kick_thr_us = 32'(kick_ms) * 32'(US_PER_MS);
        kick_done   = el_us >= kick_thr_us;
        sust_over   = el_us >= 32'((PWM_PERIOD_MS + 1) * US_PER_MS);
        if (int'(dur) > PWM_PERIOD_MS)
        begin
            sust_on = 1'b1;
        end
        else
        begin
            sust_on = el_us >= 32'(PWM_PERIOD_MS + 1 - int'(dur)) * 32'(US_PER_MS);
        end

        ph_next    = phase_reg[ch];
        off_next   = off_count_reg[ch];
        saw_next   = saw_release_reg[ch];
        start_wr   = 1'b0;
        drive_next = drive_bits_reg;
        valid_next = ack_valid;
        clr        = 8'd0;

        case (phase_reg[ch])
            PH_IDLE:
            begin
                if (act)
                begin
                    start_wr = 1'b1;
                    ph_next  = PH_QUAL;
                end
            end
            PH_QUAL:
            begin
                if (!act)
                begin
                    ph_next = PH_IDLE;
                end
                else if (el_us >= 32'(QUALIFY_US))
                begin
                    ph_next    = PH_KICK;
                    valid_next = valid_next | bit_sel;
                    saw_next   = 1'b0;
                    drive_next = drive_next | bit_sel;
                    start_wr   = 1'b1;
                    clr        = auto_clear_mask_reg & bit_sel;
                end
            end
            PH_KICK:
            begin
                if (!act)
                begin
                    saw_next = 1'b1;
                end
                if (kick_done)
                begin
                    drive_next = drive_next & ~bit_sel;
                    if (dur != 4'd0 && act)
                    begin
                        ph_next = PH_SUST;
                    end
                    else
                    begin
                        ph_next  = PH_OFF;
                        off_next = 5'd0;
                    end
                    start_wr = 1'b1;
                end
            end
            PH_SUST:
            begin
                if (act)
                begin
                    if (sust_over)
                    begin
                        drive_next = drive_next & ~bit_sel;
                        start_wr   = 1'b1;
                    end
                    else if (sust_on)
                    begin
                        drive_next = drive_next | bit_sel;
                    end
                end
                else
                begin
                    drive_next = drive_next & ~bit_sel;
                    ph_next    = PH_IDLE;
                end
            end
            PH_WAIT:
            begin
                if (!act)
                begin
                    ph_next = PH_IDLE;
                end
            end
            PH_OFF:
            begin
                if (!act)
                begin
                    saw_next = 1'b1;
                end
                if (kick_done)
                begin
                    off_next = off_count_reg[ch] + 5'd1;
                    if (off_next >= 5'(minoff))
                    begin
                        ph_next = saw_next ? PH_IDLE : PH_WAIT;
                    end
                    else
                    begin
                        start_wr = 1'b1;
                    end
                end
            end
            default:
            begin
                ph_next = phase_reg[ch];
            end
        endcase

        // mirror raw levels of switchless channels
        mirror = ~use_switch_mask_reg & CHAN_MASK;
        if (any_en)
        begin
            valid_next = (valid_next & ~mirror) | (in_reg.switch_levels & en & mirror);
        end
        else
        begin
            valid_next = ack_valid;
            drive_next = drive_bits_reg;
            clr        = 8'd0;
            ph_next    = phase_reg[ch];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg     <= '0;
            use_switch_mask_reg <= '0;
            auto_clear_mask_reg <= '0;
            kick_time_table_reg <= '0;
            min_off_table_reg   <= '0;
            duty_table_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE_MASK:     enable_mask_reg     <= cfg_data[7:0];
                REG_USE_SWITCH_MASK: use_switch_mask_reg <= cfg_data[7:0];
                REG_AUTO_CLEAR_MASK: auto_clear_mask_reg <= cfg_data[7:0];
                REG_KICK_TIME_TABLE: kick_time_table_reg <= cfg_data;
                REG_MIN_OFF_TABLE:   min_off_table_reg   <= cfg_data[31:0];
                REG_DUTY_TABLE:      duty_table_reg      <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register and channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            drive_bits_reg <= '0;
            valid_bits_reg <= '0;
            cur_chan_reg   <= '0;
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                phase_reg[i]       <= PH_IDLE;
                off_count_reg[i]   <= '0;
                saw_release_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (process)
            begin
                valid_bits_reg <= valid_next;
                if (any_en)
                begin
                    drive_bits_reg      <= drive_next;
                    cur_chan_reg        <= next_ch;
                    phase_reg[ch]       <= ph_next;
                    off_count_reg[ch]   <= off_next;
                    saw_release_reg[ch] <= saw_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_item;
        end
        if (process && any_en && start_wr)
        begin
            start_us_reg[ch] <= in_reg.now_us;
        end
        if (process)
        begin
            out_reg.drive          <= drive_next;
            out_reg.valid_switch   <= valid_next;
            out_reg.request_clear  <= clr;
            out_reg.served_channel <= ch;
            out_reg.served_phase   <= 3'(ph_next);
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (process)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    a_clr_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(out_item.request_clear))
        else $error("request_clear has more than one bit set");

    a_clr_on_kick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.request_clear != 8'd0)
        |-> out_item.served_phase == 3'(PH_KICK)
            && (out_item.drive & out_item.request_clear) != 8'd0)
        else $error("request clear without kick start");

    a_served_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        process && any_en |-> en[ch])
        else $error("served channel is not enabled");

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_bits_reg & ~CHAN_MASK) == 8'd0)
        else $error("drive on a channel that does not exist");

endmodule

// File: test/solenoid_kick_hold_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the solenoid kick/hold sequencer.
module solenoid_kick_hold_sequencer_tb;

    import skh_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    solenoid_kick_hold_sequencer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Predictor copy of the register file
    logic [7:0]  en_mask = '0;
    logic [7:0]  sw_mask = '0;
    logic [7:0]  clr_mask = '0;
    logic [63:0] kick_ms_tbl = '0;
    logic [31:0] min_off_tbl = '0;
    logic [31:0] duty_tbl = '0;

    // Predictor copy of the channel state
    phase_t      ch_phase [8] = '{default: PH_IDLE};
    logic [4:0]  off_steps [8] = '{default: '0};
    logic        released [8] = '{default: 1'b0};
    logic [31:0] start_us [8] = '{default: '0};
    logic [7:0]  drive_bits = '0;
    logic [7:0]  valid_bits = '0;
    logic [2:0]  poll_ch = '0;

    in_item_t  polls_to_send [$];
    out_item_t predicted_results [$];
    int        polls_queued = 0;
    int        polls_taken = 0;
    int        mismatches = 0;

    // Stimulus state: held triggers and running time
    logic [7:0]  held_sw = '0;
    logic [7:0]  held_req = '0;
    logic [31:0] now_clk = '0;

    function automatic out_item_t serve_poll(in_item_t p);
        out_item_t   r;
        logic [7:0]  en;
        logic [7:0]  ch_bit;
        logic [7:0]  mirror;
        logic [7:0]  kick_ms;
        logic [3:0]  off_min;
        logic [3:0]  on_ms;
        logic [31:0] el_us;
        logic [31:0] el_ms;
        logic [2:0]  ch;
        logic [2:0]  nxt;
        logic        act;
        phase_t      ph;
        r = '0;
        valid_bits = valid_bits & ~p.valid_ack;
        ch = poll_ch;
        en = en_mask & CHAN_MASK;
        if (en == '0)
        begin
            r.drive = drive_bits;
            r.valid_switch = valid_bits;
            r.served_channel = ch;
            r.served_phase = ch_phase[ch];
            return r;
        end
        // skip forward to the first enabled channel
        for (int k = 0; k < 8 && !en[ch]; k++)
            ch = ch + 3'd1;
        ch_bit = 8'(1) << ch;
        kick_ms = kick_ms_tbl[8*ch +: 8];
        off_min = min_off_tbl[4*ch +: 4];
        on_ms = duty_tbl[4*ch +: 4];
        act = (sw_mask[ch] && !p.switch_levels[ch]) || p.proc_requests[ch];
        el_us = p.now_us - start_us[ch];
        el_ms = el_us / US_PER_MS;
        ph = ch_phase[ch];
        case (ph)
            PH_IDLE:
            begin
                if (act)
                begin
                    start_us[ch] = p.now_us;
                    ph = PH_QUAL;
                end
            end
            PH_QUAL:
            begin
                if (!act)
                    ph = PH_IDLE;
                else if (el_us >= QUALIFY_US)
                begin
                    ph = PH_KICK;
                    valid_bits = valid_bits | ch_bit;
                    released[ch] = 1'b0;
                    drive_bits = drive_bits | ch_bit;
                    start_us[ch] = p.now_us;
                    if (clr_mask[ch])
                        r.request_clear = ch_bit;
                end
            end
            PH_KICK:
            begin
                if (!act)
                    released[ch] = 1'b1;
                if (el_ms >= kick_ms)
                begin
                    drive_bits = drive_bits & ~ch_bit;
                    if (on_ms != 0 && act)
                        ph = PH_SUST;
                    else
                    begin
                        ph = PH_OFF;
                        off_steps[ch] = '0;
                    end
                    start_us[ch] = p.now_us;
                end
            end
            PH_SUST:
            begin
                if (act)
                begin
                    if (el_ms > PWM_PERIOD_MS)
                    begin
                        drive_bits = drive_bits & ~ch_bit;
                        start_us[ch] = p.now_us;
                    end
                    else if (el_ms > PWM_PERIOD_MS - int'(on_ms))
                        drive_bits = drive_bits | ch_bit;
                end
                else
                begin
                    drive_bits = drive_bits & ~ch_bit;
                    ph = PH_IDLE;
                end
            end
            PH_WAIT:
            begin
                if (!act)
                    ph = PH_IDLE;
            end
            PH_OFF:
            begin
                if (!act)
                    released[ch] = 1'b1;
                if (el_ms >= kick_ms)
                begin
                    off_steps[ch] = off_steps[ch] + 5'd1;
                    if (off_steps[ch] >= off_min)
                        ph = released[ch] ? PH_IDLE : PH_WAIT;
                    else
                        start_us[ch] = p.now_us;
                end
            end
            default:
            begin
            end
        endcase
        ch_phase[ch] = ph;
        mirror = ~sw_mask & CHAN_MASK;
        valid_bits = (valid_bits & ~mirror) | (p.switch_levels & en & mirror);
        nxt = ch + 3'd1;
        while (!en[nxt])
            nxt = nxt + 3'd1;
        poll_ch = nxt;
        r.drive = drive_bits;
        r.valid_switch = valid_bits;
        r.served_channel = ch;
        r.served_phase = ph;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_poll(in_item_t p);
        polls_to_send.push_back(p);
        polls_queued++;
    endtask

    // Mostly held presses with random timing, some pure noise polls
    task automatic queue_polls(int count, int unsigned step_max, int unsigned hold_len);
        in_item_t p;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(11) == 0)
                p = 56'({$urandom(), $urandom()});
            else
            begin
                for (int b = 0; b < 8; b++)
                begin
                    if ($urandom_range(hold_len - 1) == 0)
                        held_sw[b] = ~held_sw[b];
                    if ($urandom_range(hold_len - 1) == 0)
                        held_req[b] = ~held_req[b];
                end
                now_clk = now_clk + $urandom_range(step_max);
                p.switch_levels = ~held_sw;
                p.proc_requests = held_req;
                p.now_us = now_clk;
                p.valid_ack = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'h00;
            end
            push_poll(p);
        end
    endtask

    task automatic wait_drained();
        while (polls_taken != polls_queued || predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(logic [7:0] en, logic [7:0] sw, logic [7:0] clr,
                                 logic [63:0] kick, logic [31:0] moff, logic [31:0] duty);
        logic [63:0] vals [6];
        vals = '{64'(en), 64'(sw), 64'(clr), kick, 64'(moff), 64'(duty)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_index <= cfg_reg_t'(i);
            cfg_data <= vals[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (cfg_reg_t'(i))
                REG_ENABLE_MASK:     en_mask = vals[i][7:0];
                REG_USE_SWITCH_MASK: sw_mask = vals[i][7:0];
                REG_AUTO_CLEAR_MASK: clr_mask = vals[i][7:0];
                REG_KICK_TIME_TABLE: kick_ms_tbl = vals[i];
                REG_MIN_OFF_TABLE:   min_off_tbl = vals[i][31:0];
                REG_DUTY_TABLE:      duty_tbl = vals[i][31:0];
                default:
                begin
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] short_kicks(int unsigned max_ms);
        logic [63:0] t;
        for (int b = 0; b < 8; b++)
            t[8*b +: 8] = 8'($urandom_range(max_ms));
        return t;
    endfunction

    // Sender: bursts of requests with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_results.push_back(serve_poll(in_item));
                polls_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || polls_to_send.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_item <= polls_to_send.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern rerolled each time the 7-bit pattern counter wraps
    logic [15:0] ready_pat = 16'hFFFF;
    logic [6:0]  pat_cyc = '0;

    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result with no request outstanding: %0h", out_item);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("drive", want.drive, out_item.drive);
                    check_field("valid_switch", want.valid_switch, out_item.valid_switch);
                    check_field("request_clear", want.request_clear, out_item.request_clear);
                    check_field("served_channel", 8'(want.served_channel),
                                8'(out_item.served_channel));
                    check_field("served_phase", 8'(want.served_phase),
                                8'(out_item.served_phase));
                end
            end
            pat_cyc = pat_cyc + 7'd1;
            if (pat_cyc == '0)
            begin
                case ($urandom_range(3))
                    0: ready_pat = 16'hFFFF;
                    1: ready_pat = 16'($urandom()) & 16'($urandom()) | 16'h0001;
                    default: ready_pat = 16'($urandom()) | 16'h0001;
                endcase
            end
            out_ready <= ready_pat[pat_cyc[3:0]];
        end
    end

    // Watchdog: no request or result moving for too long
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** solenoid_kick_hold_sequencer: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        in_item_t p;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no channel enabled: only the acknowledge acts
        push_poll('0);
        push_poll('1);
        push_poll({8'h5A, 8'hA5, 32'h1234_5678, 8'h0F});
        wait_drained();

        // two channels, the current one disabled; one switch, one request;
        // time wraps during the sequence
        load_settings(8'h06, 8'h02, 8'h04, 64'h0000_0000_0001_0200,
                      32'h0000_0200, 32'h0000_00F0);
        now_clk = 32'hFFFF_FC00;
        for (int k = 0; k < 18; k++)
        begin
            p.switch_levels = 8'hFF;
            p.switch_levels[1] = (k >= 12);
            p.switch_levels[2] = k[0];
            p.proc_requests = (k < 12) ? 8'h05 : 8'h01;
            p.now_us = now_clk;
            p.valid_ack = (k == 6) ? 8'hFF : 8'h00;
            push_poll(p);
            now_clk = now_clk + 600;
        end
        wait_drained();

        load_settings(8'hFF, 8'h0F, 8'hF0, short_kicks(5), $urandom(), $urandom());
        queue_polls(80, 1500, 80);
        wait_drained();

        // zero kick time, full duty
        load_settings(8'h01, 8'h01, 8'h01, 64'h0, 32'h0, 32'hFFFF_FFFF);
        queue_polls(60, 3000, 10);
        wait_drained();

        // longest kick and off times
        load_settings(8'h5A, 8'hFF, 8'hFF, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_polls(80, 150000, 30);
        wait_drained();

        load_settings(8'h80, 8'h00, 8'h00, 64'h0, 32'h0, 32'h0);
        queue_polls(40, 2000, 8);
        wait_drained();

        for (int r = 0; r < 2; r++)
        begin
            load_settings(8'($urandom()), 8'($urandom()), 8'($urandom()),
                          short_kicks(7), $urandom(), $urandom());
            queue_polls(70, 2500, 40);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("** solenoid_kick_hold_sequencer: PASSED **");
        else
            $display("** solenoid_kick_hold_sequencer: FAILED **");
        $finish;
    end

endmodule

// File: files.f
sv/skh_pkg.sv
sv/solenoid_kick_hold_sequencer.sv
test/solenoid_kick_hold_sequencer_tb.sv
